[hdl/sckd_pkg.sv]
// ----------------------------------------------------------------------------
// SimCC keypoint decoder package
// Shared widths, register indexes, limits and the structs passed between the
// row tracker and the top-level sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sckd_pkg;

  localparam int BIN_IDX_W  = 10;
  localparam int BINS_W     = 11;
  localparam int GEO_W      = 12;
  localparam int TGT_W      = 13;
  localparam int JOINT_W    = 6;
  localparam int JC_W       = 7;
  localparam int COORD_W    = 17;
  localparam int CONF_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int FRAC_BITS_DEF  = 4;
  localparam int SCORE_BITS_DEF = 16;

  localparam int COORD_MAX = 131071;
  localparam int CONF_MAX  = 32767;
  localparam int BINS_MAX  = 1024;
  localparam int TGT_MAX   = 4096;
  localparam int JC_MAX    = 64;

  localparam logic [BINS_W-1:0] BINS_X_RST = 11'd384;
  localparam logic [BINS_W-1:0] BINS_Y_RST = 11'd512;
  localparam logic [TGT_W-1:0]  TGT_W_RST  = 13'd192;
  localparam logic [TGT_W-1:0]  TGT_H_RST  = 13'd256;
  localparam logic [JC_W-1:0]   JC_RST     = 7'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINS_X      = 3'd0,
    REG_BINS_Y      = 3'd1,
    REG_TARGET_W    = 3'd2,
    REG_TARGET_H    = 3'd3,
    REG_JOINT_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [GEO_W-1:0] w;
    logic [GEO_W-1:0] h;
    logic [GEO_W-1:0] x;
    logic [GEO_W-1:0] y;
  } region_t;

  typedef struct packed {
    logic                 fire;
    logic [BIN_IDX_W-1:0] x_index;
    logic [BIN_IDX_W-1:0] y_index;
    logic [JOINT_W-1:0]   joint;
    logic [CONF_W-1:0]    confidence;
    logic                 last;
  } joint_evt_t;

endpackage

`default_nettype wire

[hdl/sckd_divider.sv]
// ----------------------------------------------------------------------------
// SimCC keypoint decoder divider
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module sckd_divider
  import sckd_pkg::*;
#(
  parameter int NUM_W = 26
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numerator,
  input  wire logic [TGT_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [TGT_W-1:0]   den;
  logic [TGT_W:0]     rem;
  logic [TGT_W:0]     rem_sh;
  logic               ge;

  assign rem_sh = {rem[TGT_W-1:0], quotient[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= numerator;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
      quotient <= {quotient[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hdl/sckd_row_tracker.sv]
// ----------------------------------------------------------------------------
// SimCC keypoint decoder row tracker
// Keeps the running maximum per score row, the phase, the joint number and
// the region geometry, and flags each completed joint.
// ----------------------------------------------------------------------------
`default_nettype none

module sckd_row_tracker
  import sckd_pkg::*;
#(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  func,
  input  wire logic [SCORE_BITS-1:0] score,
  input  wire region_t               region_in,
  input  wire logic [BINS_W-1:0]     bins_x,
  input  wire logic [BINS_W-1:0]     bins_y,
  input  wire logic [JC_W-1:0]       joint_count,
  output region_t                    region,
  output joint_evt_t                 evt
);

  localparam int VAL_W = SCORE_BITS - 1;

  logic                 in_vertical;
  logic [BIN_IDX_W-1:0] bin_count;
  logic [JOINT_W-1:0]   joint_now;
  logic [VAL_W-1:0]     best_value;
  logic [BIN_IDX_W-1:0] best_index;
  logic [BIN_IDX_W-1:0] held_x_index;
  logic [VAL_W-1:0]     held_x_value;

  logic                 positive;
  logic                 upd;
  logic [VAL_W-1:0]     cur_value;
  logic [BIN_IDX_W-1:0] cur_index;
  logic [BINS_W-1:0]    nb;
  logic                 row_end;
  logic [SCORE_BITS-1:0] sum;
  logic [SCORE_BITS+CONF_W-1:0] conf_wide;
  logic                 last;

  assign positive  = !score[SCORE_BITS-1] && (score != '0);
  assign upd       = positive && (score[VAL_W-1:0] > best_value);
  assign cur_value = upd ? score[VAL_W-1:0] : best_value;
  assign cur_index = upd ? bin_count : best_index;
  assign nb        = in_vertical ? bins_y : bins_x;
  assign row_end   = (BINS_W'(bin_count) + 1'b1) >= nb;
  assign sum       = {1'b0, held_x_value} + {1'b0, cur_value};
  assign conf_wide = (SCORE_BITS+CONF_W)'(sum[SCORE_BITS-1:1]);
  assign last      = (JC_W'(joint_now) + 1'b1) >= joint_count;

  always_comb begin
    evt.fire       = accept && func && row_end && in_vertical;
    evt.x_index    = held_x_index;
    evt.y_index    = cur_index;
    evt.joint      = joint_now;
    evt.last       = last;
    evt.confidence = (conf_wide > (SCORE_BITS+CONF_W)'(CONF_MAX)) ?
                     CONF_W'(CONF_MAX) : conf_wide[CONF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vertical  <= 1'b0;
      bin_count    <= '0;
      joint_now    <= '0;
      best_value   <= '0;
      best_index   <= '0;
      held_x_index <= '0;
      held_x_value <= '0;
      region       <= '0;
    end else if (accept) begin
      if (!func) begin
        region       <= region_in;
        in_vertical  <= 1'b0;
        bin_count    <= '0;
        joint_now    <= '0;
        best_value   <= '0;
        best_index   <= '0;
        held_x_index <= '0;
        held_x_value <= '0;
      end else if (!row_end) begin
        bin_count  <= bin_count + 1'b1;
        best_value <= cur_value;
        best_index <= cur_index;
      end else if (!in_vertical) begin
        held_x_index <= cur_index;
        held_x_value <= cur_value;
        in_vertical  <= 1'b1;
        bin_count    <= '0;
        best_value   <= '0;
        best_index   <= '0;
      end else begin
        joint_now    <= last ? '0 : (joint_now + 1'b1);
        in_vertical  <= 1'b0;
        bin_count    <= '0;
        best_value   <= '0;
        best_index   <= '0;
        held_x_index <= '0;
        held_x_value <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/simcc_keypoint_decoder_top.sv]
// ----------------------------------------------------------------------------
// SimCC keypoint decoder top level
// Row argmax tracking, then per joint a shared multiply and iterative divide
// that turn the two bin indexes into image coordinates.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Contents
//  s_*      s_tvalid s_tready s_tdata s_tuser region or score item
//  m_*      m_tvalid m_tready m_tdata m_tlast  decoded keypoint item
//  cfg_*    cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A region item or a score item that does not end a joint updates only the
// row tracker. The score item that ends a joint starts the sequencer: per axis
// a multiply state, a load state, the divider iterations and an add state,
// then the output state, which loads the output register. Most of this time
// goes to the single restoring divider. s_tready is low during that time and,
// beyond it, while the previous item still waits in the output register on
// m_tready. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module simcc_keypoint_decoder_top
  import sckd_pkg::*;
#(
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // score, region_w, region_h, offset_x, offset_y
  input  wire logic [((SCORE_BITS+4*GEO_W+7)/8)*8-1:0] s_tdata,
  // func
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // joint_index, coord_x, coord_y, confidence
  output logic [55:0]                m_tdata,
  // last_joint
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = BIN_IDX_W + GEO_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int SUM_W  = NUM_W + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } seq_state_t;

  logic [BINS_W-1:0] bins_x;
  logic [BINS_W-1:0] bins_y;
  logic [TGT_W-1:0]  target_w;
  logic [TGT_W-1:0]  target_h;
  logic [JC_W-1:0]   joint_count;

  seq_state_t        state;
  seq_state_t        state_next;
  logic              axis;
  joint_evt_t        job;
  joint_evt_t        evt;
  region_t           region;
  region_t           region_in;
  logic              in_accept;
  logic [PROD_W-1:0] product;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord;
  logic [SUM_W-1:0]  coord_sum;
  logic              div_done;
  logic [NUM_W-1:0]  quotient;
  logic [BIN_IDX_W-1:0] idx_sel;
  logic [GEO_W-1:0]  size_sel;
  logic [GEO_W-1:0]  off_sel;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    region_in.w = s_tdata[SCORE_BITS +: GEO_W];
    region_in.h = s_tdata[SCORE_BITS+GEO_W +: GEO_W];
    region_in.x = s_tdata[SCORE_BITS+2*GEO_W +: GEO_W];
    region_in.y = s_tdata[SCORE_BITS+3*GEO_W +: GEO_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_x      <= BINS_X_RST;
      bins_y      <= BINS_Y_RST;
      target_w    <= TGT_W_RST;
      target_h    <= TGT_H_RST;
      joint_count <= JC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BINS_X: begin
          bins_x <= (cfg_data[BINS_W-1:0] == '0) ? BINS_W'(1) :
                    (cfg_data[BINS_W-1:0] > BINS_W'(BINS_MAX)) ? BINS_W'(BINS_MAX) :
                    cfg_data[BINS_W-1:0];
        end
        REG_BINS_Y: begin
          bins_y <= (cfg_data[BINS_W-1:0] == '0) ? BINS_W'(1) :
                    (cfg_data[BINS_W-1:0] > BINS_W'(BINS_MAX)) ? BINS_W'(BINS_MAX) :
                    cfg_data[BINS_W-1:0];
        end
        REG_TARGET_W: begin
          target_w <= (cfg_data == '0) ? TGT_W'(1) :
                      (cfg_data > TGT_W'(TGT_MAX)) ? TGT_W'(TGT_MAX) : cfg_data;
        end
        REG_TARGET_H: begin
          target_h <= (cfg_data == '0) ? TGT_W'(1) :
                      (cfg_data > TGT_W'(TGT_MAX)) ? TGT_W'(TGT_MAX) : cfg_data;
        end
        REG_JOINT_COUNT: begin
          joint_count <= (cfg_data[JC_W-1:0] == '0) ? JC_W'(1) :
                         (cfg_data[JC_W-1:0] > JC_W'(JC_MAX)) ? JC_W'(JC_MAX) :
                         cfg_data[JC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sckd_row_tracker #(
    .SCORE_BITS(SCORE_BITS)
  ) u_row_tracker (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .func       (s_tuser),
    .score      (s_tdata[SCORE_BITS-1:0]),
    .region_in  (region_in),
    .bins_x     (bins_x),
    .bins_y     (bins_y),
    .joint_count(joint_count),
    .region     (region),
    .evt        (evt)
  );

  assign idx_sel  = axis ? job.y_index : job.x_index;
  assign size_sel = axis ? region.h : region.w;
  assign off_sel  = axis ? region.y : region.x;

  sckd_divider #(
    .NUM_W(NUM_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .numerator(NUM_W'(product) << FRAC_BITS),
    .divisor  (axis ? target_h : target_w),
    .done     (div_done),
    .quotient (quotient)
  );

  assign coord_sum = SUM_W'(quotient) + (SUM_W'(off_sel) << FRAC_BITS);
  assign coord     = (coord_sum > SUM_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) :
                     coord_sum[COORD_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (evt.fire) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD:  state_next = axis ? S_OUT : S_MUL;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        axis <= 1'b0;
      end else if (state == S_ADD) begin
        axis <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && evt.fire) begin
      job <= evt;
    end
    if (state == S_MUL) begin
      product <= PROD_W'(idx_sel) * PROD_W'(size_sel);
    end
    if (state == S_ADD) begin
      if (axis) begin
        coord_y <= coord;
      end else begin
        coord_x <= coord;
      end
    end
    if (state == S_OUT && out_free) begin
      m_tdata <= {1'b0, job.confidence, coord_y, coord_x, job.joint};
      m_tlast <= job.last;
    end
  end

endmodule

`default_nettype wire

[bench/tb_simcc_keypoint_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SimCC keypoint decoder testbench
// Drives region and score items into the decoder, predicts each keypoint
// from its own row-argmax and scaling model or from the directed table, and
// checks the output stream. A short table of directed items comes first, then
// register settings with random sequences, a long output stall and one pass
// whose saturated bin count is cut short mid-row by a register write.
// ----------------------------------------------------------------------------
module tb_simcc_keypoint_decoder_top;
  import sckd_pkg::*;

  localparam int SDATA_W = ((SCORE_BITS_DEF + 4 * GEO_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 70;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [CONF_W-1:0]  conf;
    logic               is_last;
  } keypoint_t;

  typedef struct {
    bit          func;
    logic [15:0] score;
    region_t     rg;
    bit          typed;
    keypoint_t   kp;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [55:0]        m_tdata;
  logic               m_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [BINS_W-1:0] set_bins_x = BINS_X_RST;
  logic [BINS_W-1:0] set_bins_y = BINS_Y_RST;
  logic [TGT_W-1:0]  set_tgt_w  = TGT_W_RST;
  logic [TGT_W-1:0]  set_tgt_h  = TGT_H_RST;
  logic [JC_W-1:0]   set_joints = JC_RST;

  bit                  in_vert = 1'b0;
  int                  bin_cnt = 0;
  logic [JOINT_W-1:0]  joint_now = '0;
  logic [CONF_W-1:0]   best_val = '0;
  int                  best_idx = 0;
  int                  hx_idx = 0;
  logic [CONF_W-1:0]   hx_val = '0;
  region_t             held_rg = '0;

  keypoint_t keypoints_due[$];
  stim_row_t dir_tab[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_req = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_results = 0;
  int n_err = 0;
  int n_settings = 0;

  simcc_keypoint_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] to_subpixel(input int idx, input int size,
                                                     input int tgt, input int off);
    longint v;
    v = ((longint'(idx) * size) << FRAC_BITS_DEF) / clamp_int(tgt, 1, TGT_MAX);
    v = v + (longint'(off) << FRAC_BITS_DEF);
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  task automatic decode_item(input bit func, input logic [15:0] score, input region_t rg,
                             output bit fired, output keypoint_t kp);
    int n_bins;
    int conf;
    bit is_last;
    fired = 1'b0;
    kp = '0;
    if (!func) begin
      held_rg = rg;
      in_vert = 1'b0;
      bin_cnt = 0;
      best_val = '0;
      best_idx = 0;
      joint_now = '0;
      hx_idx = 0;
      hx_val = '0;
      return;
    end
    if (!score[15] && score != 16'h0000 && score[14:0] > best_val) begin
      best_val = score[14:0];
      best_idx = bin_cnt;
    end
    n_bins = clamp_int(in_vert ? int'(set_bins_y) : int'(set_bins_x), 1, BINS_MAX);
    if (bin_cnt + 1 < n_bins) begin
      bin_cnt++;
      return;
    end
    if (!in_vert) begin
      hx_idx = best_idx;
      hx_val = best_val;
      in_vert = 1'b1;
      bin_cnt = 0;
      best_val = '0;
      best_idx = 0;
      return;
    end
    is_last = (int'(joint_now) + 1 >= clamp_int(int'(set_joints), 1, JC_MAX));
    conf = (int'(hx_val) + int'(best_val)) >> 1;
    kp.joint = joint_now;
    kp.cx = to_subpixel(hx_idx, held_rg.w, set_tgt_w, held_rg.x);
    kp.cy = to_subpixel(best_idx, held_rg.h, set_tgt_h, held_rg.y);
    kp.conf = (conf > CONF_MAX) ? CONF_W'(CONF_MAX) : CONF_W'(conf);
    kp.is_last = is_last;
    joint_now = is_last ? '0 : joint_now + 1'b1;
    in_vert = 1'b0;
    bin_cnt = 0;
    best_val = '0;
    best_idx = 0;
    hx_idx = 0;
    hx_val = '0;
    fired = 1'b1;
  endtask

  task automatic push_item(input bit func, input logic [15:0] score, input region_t rg,
                           input bit typed, input keypoint_t typed_kp);
    bit fired;
    keypoint_t kp;
    while (tx_idle && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {rg.y, rg.x, rg.h, rg.w, score};
    do @(posedge clk); while (!s_tready);
    n_items++;
    decode_item(func, score, rg, fired, kp);
    if (typed) keypoints_due = {keypoints_due, typed_kp};
    else if (fired) keypoints_due = {keypoints_due, kp};
  endtask

  task automatic wait_drained(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (keypoints_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_BINS_X:      set_bins_x = v[BINS_W-1:0];
      REG_BINS_Y:      set_bins_y = v[BINS_W-1:0];
      REG_TARGET_W:    set_tgt_w = v[TGT_W-1:0];
      REG_TARGET_H:    set_tgt_h = v[TGT_W-1:0];
      REG_JOINT_COUNT: set_joints = v[JC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_keypoint(input logic [55:0] d, input logic tl);
    keypoint_t got;
    keypoint_t want;
    got.joint   = d[5:0];
    got.cx      = d[22:6];
    got.cy      = d[39:23];
    got.conf    = d[54:40];
    got.is_last = tl;
    n_results++;
    if (keypoints_due.size() == 0) begin
      n_err++;
      if (n_err <= 10)
        $display("Unexpected keypoint: joint %0d x %0d y %0d conf %0d last %0d",
                 got.joint, got.cx, got.cy, got.conf, got.is_last);
      return;
    end
    want = keypoints_due.pop_front();
    if (got.joint !== want.joint || got.cx !== want.cx || got.cy !== want.cy ||
        got.conf !== want.conf || got.is_last !== want.is_last) begin
      n_err++;
      if (n_err <= 10)
        $display("Keypoint mismatch: expected joint %0d x %0d y %0d conf %0d last %0d, %s",
                 want.joint, want.cx, want.cy, want.conf, want.is_last,
                 $sformatf("got joint %0d x %0d y %0d conf %0d last %0d",
                           got.joint, got.cx, got.cy, got.conf, got.is_last));
    end
  endtask

  function automatic stim_row_t sc(input logic [15:0] s);
    stim_row_t r;
    r = '{func: 1'b1, score: s, rg: '0, typed: 1'b0, kp: '0};
    return r;
  endfunction

  function automatic stim_row_t rgn(input logic [11:0] w, input logic [11:0] h,
                                    input logic [11:0] x, input logic [11:0] y);
    stim_row_t r;
    r = '{func: 1'b0, score: 16'h0000, rg: {w, h, x, y}, typed: 1'b0, kp: '0};
    return r;
  endfunction

  function automatic stim_row_t sc_exp(input logic [15:0] s, input int j, input int cx,
                                       input int cy, input int conf, input bit is_last);
    stim_row_t r;
    r = sc(s);
    r.typed = 1'b1;
    r.kp = '{joint: JOINT_W'(j), cx: COORD_W'(cx), cy: COORD_W'(cy),
             conf: CONF_W'(conf), is_last: is_last};
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_keypoint(m_tdata, m_tlast);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_idle && $urandom_range(99) < 23);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    region_t     rg;
    logic [15:0] s;
    logic [15:0] prev_s;
    int          n_run;
    int          score_cnt;
    int          bx;
    int          by;
    int          tw;
    int          th;
    int          jc;
    bit          big;

    prev_s = 16'h0000;
    // With two bins per row and two joints per region: an all-nonpositive
    // joint, a tied row plus the final joint, a wrap with the same region,
    // then region items that cut a row and a held horizontal result.
    dir_tab = {rgn(12'h000, 12'h000, 12'h000, 12'h000),
               sc(16'h8000), sc(16'h0000), sc(16'hFFFF),
               sc_exp(16'hFF00, 0, 0, 0, 0, 1'b0),
               sc(16'h7FFF), sc(16'h7FFF), sc(16'h0001),
               sc_exp(16'h7FFF, 1, 0, 0, 32767, 1'b1),
               sc(16'h0005), sc(16'h0004), sc(16'h0007),
               sc_exp(16'h0003, 0, 0, 0, 6, 1'b0),
               rgn(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF),
               sc(16'h0064),
               rgn(12'd10, 12'd20, 12'd1, 12'd2),
               sc(16'h0032), sc(16'h003C), sc(16'h00C8),
               rgn(12'h5A5, 12'hA5A, 12'h123, 12'hEDC),
               sc(16'h0100), sc(16'h0000), sc(16'h0000), sc(16'h0200)};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_BINS_X, 13'd2);
    write_reg(REG_BINS_Y, 13'd2);
    write_reg(REG_JOINT_COUNT, 13'd2);
    cfg_valid <= 1'b0;
    n_settings++;
    foreach (dir_tab[i])
      push_item(dir_tab[i].func, dir_tab[i].score, dir_tab[i].rg,
                dir_tab[i].typed, dir_tab[i].kp);

    for (int p = 0; p <= 12; p++) begin
      wait_drained(SETTLE_CYCLES);
      bx = $urandom_range(1, 8);
      by = $urandom_range(1, 8);
      tw = $urandom_range(1, TGT_MAX);
      th = $urandom_range(1, TGT_MAX);
      jc = $urandom_range(1, 6);
      case (p)
        1: begin
          bx = 0;
          by = 13'h1801;
        end
        2: begin
          bx = 1;
          by = 2;
          jc = 127;
        end
        3: begin
          tw = 0;
          th = 8191;
        end
        8: jc = 13'h1F80;
        9: begin
          tw = TGT_MAX;
          th = TGT_MAX;
          jc = JC_MAX;
        end
        12: begin
          bx = 2047;
          by = 1;
          tw = 1;
          th = TGT_MAX;
          jc = 1;
        end
        default: ;
      endcase
      write_reg(REG_BINS_X, CFG_DATA_W'(bx));
      write_reg(REG_BINS_Y, CFG_DATA_W'(by));
      write_reg(REG_TARGET_W, CFG_DATA_W'(tw));
      write_reg(REG_TARGET_H, CFG_DATA_W'(th));
      write_reg(REG_JOINT_COUNT, CFG_DATA_W'(jc));
      cfg_valid <= 1'b0;
      n_settings++;

      big = (p == 12);
      n_run = big ? 303 : (p == 2 ? 200 : 52);
      tx_idle = !(p == 6 || p == 7);
      rx_idle = !(p == 6 || p == 7);
      if (p == 4) hold_req = 400;
      score_cnt = 0;

      for (int k = 0; k < n_run; k++) begin
        if (p == 5 && k == 45) wait_drained(0);
        // The long horizontal row ends early once the bin count drops to one.
        if (big && k == n_run - 2) begin
          wait_drained(0);
          write_reg(REG_BINS_X, 13'd1);
          cfg_valid <= 1'b0;
          n_settings++;
        end
        rg.w = $urandom_range(0, 4095);
        rg.h = $urandom_range(0, 4095);
        rg.x = $urandom_range(0, 4095);
        rg.y = $urandom_range(0, 4095);
        if (big ? (k == 0) : ($urandom_range(99) < 4)) begin
          push_item(1'b0, 16'($urandom), rg, 1'b0, '0);
        end else begin
          if (big) begin
            // A rising ramp puts the maximum of each row on its last bin.
            s = 16'((score_cnt % BINS_MAX) + 1);
          end else begin
            case ($urandom_range(7))
              0: s = 16'h0000;
              1: s = 16'h7FFF;
              2: s = 16'h8000;
              3: s = prev_s;
              default: s = 16'($urandom);
            endcase
          end
          score_cnt++;
          prev_s = s;
          push_item(1'b1, s, rg, 1'b0, '0);
        end
      end
    end

    tx_idle = 1'b1;
    wait_drained(SETTLE_CYCLES);
    $display("Sent %0d items under %0d register settings and checked %0d keypoints,",
             n_items, n_settings, n_results);
    $display("with ties, mid-row region cuts, joint wrap, a row cut by a bin count change,");
    $display("coordinate saturation and output stalls.");
    if (n_err == 0 && keypoints_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d keypoints never arrived", n_err, keypoints_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[simcc_keypoint_decoder_top.f]
hdl/sckd_pkg.sv
hdl/sckd_divider.sv
hdl/sckd_row_tracker.sv
hdl/simcc_keypoint_decoder_top.sv
bench/tb_simcc_keypoint_decoder_top.sv
